FILE: src/monotone_matrix_row_minima_unit_assert.svh
// assertion macros for the row minima unit
`ifndef MONOTONE_MATRIX_ROW_MINIMA_UNIT_ASSERT_SVH
`define MONOTONE_MATRIX_ROW_MINIMA_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MMRM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mmrm assertion failed");
`define MMRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mmrm assertion failed");
`else
`define MMRM_ASSERT_IMPL(label, ante, cons)
`define MMRM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/mmrm_pkg.sv
`default_nettype none
package mmrm_pkg;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 256;
  localparam int VALUE_BITS = 32;
  localparam int LEVELS     = 8;
  localparam int MAT_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int STK_DEPTH  = LEVELS * MAX_ROWS;

  localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [1:0] CFG_COL_COUNT = 2'd1;

  typedef struct packed {
    logic [5:0]         entry_row;
    logic [7:0]         entry_col;
    logic signed [31:0] entry_value;
    logic               load_done;
  } in_t;

  typedef struct packed {
    logic [5:0]         out_row;
    logic [7:0]         min_col;
    logic signed [31:0] min_value;
    logic               last_row;
  } out_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] pos;
  } stk_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED_INIT, S_RED_FETCH, S_RED_CWAIT, S_RED_CHK, S_RED_T1, S_RED_T2,
    S_RED_T3, S_RED_PUSH, S_INT_INIT, S_INT_ROW, S_INT_AWAIT, S_INT_S0, S_INT_C1,
    S_INT_C2, S_OUT_A, S_OUT_B, S_OUT_C
  } state_t;
endpackage
`default_nettype wire

FILE: src/monotone_matrix_row_minima_unit.sv
// Leftmost row minima (SMAWK) of a totally monotone matrix held in a 64x256 store.
// Entries are loaded with start, one per cycle while busy is low; an entry with
// load_done set is stored and then starts the run, and busy stays high until the
// last result. The run is a sequencer over three single-port memories (matrix,
// column stacks, row answers), each with a registered read; every reduce
// comparison steps through states CHK, T1, T2 and T3, every interpolate candidate
// through C1 and C2, and every result through OUT_A, OUT_B and OUT_C.
// One result per row, in row order, each on out_data for a single cycle marked by
// out_valid; the receiver cannot stall, so it must take every result as it comes.
// Configuration is written through cfg_valid/cfg_ready only while busy is low.
`default_nettype none
module monotone_matrix_row_minima_unit
  import mmrm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_t        in_data,
  output logic            out_valid,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);
  `include "monotone_matrix_row_minima_unit_assert.svh"

  state_t state_r, state_nxt;
  logic [2:0]  lvl_r, lvl_nxt;
  logic [6:0]  k_r, k_nxt;
  logic [8:0]  i_r, i_nxt;
  logic [7:0]  c_r, c_nxt;
  logic [31:0] tval_r, tval_nxt;
  logic [6:0]  bounds_r [LEVELS];
  logic        bnd_we;
  logic [6:0]  ii_r, ii_nxt, start_r, start_nxt, stop_r, stop_nxt, cur_r, cur_nxt;
  logic [31:0] best_r, best_nxt;
  stk_t        bsel_r, bsel_nxt, cand_r, cand_nxt;
  logic        first_r, first_nxt;
  logic [5:0]  oi_r, oi_nxt;
  logic [7:0]  ocol_r, ocol_nxt;
  logic [6:0]  row_count_r;
  logic [8:0]  col_count_r;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic                         mat_we, stk_we, ans_we;
  logic [$clog2(MAT_DEPTH)-1:0] mat_addr;
  logic [$clog2(STK_DEPTH)-1:0] stk_addr;
  logic [5:0]                   ans_addr;
  logic [31:0]                  mat_wdata, mat_rdata;
  stk_t                         stk_wdata, stk_rdata, ans_wdata, ans_rdata;

  logic [6:0]  m, kb, km1;
  logic [8:0]  in_count;
  logic [13:0] red_r, int_r, int_nr;
  logic        better;
  stk_t        bsel_n;

  mmrm_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat (
    .clk(clk), .we(mat_we), .addr(mat_addr), .wdata(mat_wdata), .rdata(mat_rdata));
  mmrm_ram #(.WIDTH(16), .DEPTH(STK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata));
  mmrm_ram #(.WIDTH(16), .DEPTH(MAX_ROWS)) u_ans (
    .clk(clk), .we(ans_we), .addr(ans_addr), .wdata(ans_wdata), .rdata(ans_rdata));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign m        = row_count_r >> lvl_r;
  assign kb       = bounds_r[lvl_r];
  assign km1      = kb - 7'd1;
  assign in_count = (lvl_r == 3'd0) ? col_count_r : {2'b0, bounds_r[lvl_r - 3'd1]};
  assign red_r    = ({7'b0, k_r} << lvl_r) - 14'd1;
  assign int_r    = (({7'b0, ii_r} + 14'd1) << lvl_r) - 14'd1;
  assign int_nr   = (({7'b0, ii_r} + 14'd2) << lvl_r) - 14'd1;
  assign better   = first_r || ($signed(mat_rdata) < $signed(best_r));
  assign bsel_n   = better ? cand_r : bsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_count_r <= 7'(MAX_ROWS);
      col_count_r <= 9'(MAX_COLS);
      for (int l = 0; l < LEVELS; l++) begin
        bounds_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (bnd_we) begin
        bounds_r[lvl_r] <= k_r;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROW_COUNT: begin
            if (cfg_data[6:0] == 7'd0) row_count_r <= 7'd1;
            else if (cfg_data[6:0] > 7'(MAX_ROWS)) row_count_r <= 7'(MAX_ROWS);
            else row_count_r <= cfg_data[6:0];
          end
          CFG_COL_COUNT: begin
            if (cfg_data == 9'd0) col_count_r <= 9'd1;
            else if (cfg_data > 9'(MAX_COLS)) col_count_r <= 9'(MAX_COLS);
            else col_count_r <= cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    c_r     <= c_nxt;
    tval_r  <= tval_nxt;
    ii_r    <= ii_nxt;
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
    cur_r   <= cur_nxt;
    best_r  <= best_nxt;
    bsel_r  <= bsel_nxt;
    cand_r  <= cand_nxt;
    first_r <= first_nxt;
    oi_r    <= oi_nxt;
    ocol_r  <= ocol_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    c_nxt         = c_r;
    tval_nxt      = tval_r;
    ii_nxt        = ii_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    bsel_nxt      = bsel_r;
    cand_nxt      = cand_r;
    first_nxt     = first_r;
    oi_nxt        = oi_r;
    ocol_nxt      = ocol_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    bnd_we        = 1'b0;
    mat_we        = 1'b0;
    mat_addr      = {in_data.entry_row, in_data.entry_col};
    mat_wdata     = in_data.entry_value;
    stk_we        = 1'b0;
    stk_addr      = {lvl_r, k_r[5:0]};
    stk_wdata     = '{col: c_r, pos: i_r[7:0]};
    ans_we        = 1'b0;
    ans_addr      = int_r[5:0];
    ans_wdata     = bsel_n;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mat_we = 1'b1;
          if (in_data.load_done) begin
            lvl_nxt   = 3'd0;
            state_nxt = S_RED_INIT;
          end
        end
      end
      S_RED_INIT: begin
        k_nxt     = '0;
        i_nxt     = '0;
        state_nxt = S_RED_FETCH;
      end
      S_RED_FETCH: begin
        if (i_r == in_count) begin
          bnd_we = 1'b1;
          if (lvl_r != 3'(LEVELS - 1) && (row_count_r >> (lvl_r + 3'd1)) != 7'd0) begin
            lvl_nxt   = lvl_r + 3'd1;
            state_nxt = S_RED_INIT;
          end else begin
            state_nxt = S_INT_INIT;
          end
        end else if (lvl_r == 3'd0) begin
          c_nxt     = i_r[7:0];
          state_nxt = S_RED_CHK;
        end else begin
          stk_addr  = {lvl_r - 3'd1, i_r[5:0]};
          state_nxt = S_RED_CWAIT;
        end
      end
      S_RED_CWAIT: begin
        c_nxt     = stk_rdata.col;
        state_nxt = S_RED_CHK;
      end
      S_RED_CHK: begin
        if (k_r == 7'd0) begin
          state_nxt = S_RED_PUSH;
        end else begin
          stk_addr  = {lvl_r, 6'(k_r - 7'd1)};
          state_nxt = S_RED_T1;
        end
      end
      S_RED_T1: begin
        mat_addr  = {red_r[5:0], stk_rdata.col};
        state_nxt = S_RED_T2;
      end
      S_RED_T2: begin
        tval_nxt  = mat_rdata;
        mat_addr  = {red_r[5:0], c_r};
        state_nxt = S_RED_T3;
      end
      S_RED_T3: begin
        if ($signed(mat_rdata) < $signed(tval_r)) begin
          k_nxt     = k_r - 7'd1;
          state_nxt = S_RED_CHK;
        end else begin
          state_nxt = S_RED_PUSH;
        end
      end
      S_RED_PUSH: begin
        if (k_r < m) begin
          stk_we = 1'b1;
          k_nxt  = k_r + 7'd1;
        end
        i_nxt     = i_r + 9'd1;
        state_nxt = S_RED_FETCH;
      end
      S_INT_INIT: begin
        ii_nxt    = '0;
        start_nxt = '0;
        state_nxt = S_INT_ROW;
      end
      S_INT_ROW: begin
        if (ii_r >= m) begin
          if (lvl_r == 3'd0) begin
            oi_nxt    = '0;
            state_nxt = S_OUT_A;
          end else begin
            lvl_nxt   = lvl_r - 3'd1;
            state_nxt = S_INT_INIT;
          end
        end else if (ii_r + 7'd1 < m) begin
          ans_addr  = int_nr[5:0];
          state_nxt = S_INT_AWAIT;
        end else begin
          stop_nxt  = km1;
          state_nxt = S_INT_S0;
        end
      end
      S_INT_AWAIT: begin
        stop_nxt  = (ans_rdata.pos > {1'b0, km1}) ? km1 : ans_rdata.pos[6:0];
        state_nxt = S_INT_S0;
      end
      S_INT_S0: begin
        cur_nxt   = (start_r > km1) ? km1 : start_r;
        stk_addr  = {lvl_r, cur_nxt[5:0]};
        first_nxt = 1'b1;
        state_nxt = S_INT_C1;
      end
      S_INT_C1: begin
        cand_nxt  = stk_rdata;
        mat_addr  = {int_r[5:0], stk_rdata.col};
        state_nxt = S_INT_C2;
      end
      S_INT_C2: begin
        first_nxt = 1'b0;
        bsel_nxt  = bsel_n;
        if (better) begin
          best_nxt = mat_rdata;
        end
        if (cur_r >= stop_r) begin
          ans_we    = 1'b1;
          start_nxt = stop_r;
          ii_nxt    = ii_r + 7'd2;
          state_nxt = S_INT_ROW;
        end else begin
          cur_nxt   = cur_r + 7'd1;
          stk_addr  = {lvl_r, cur_nxt[5:0]};
          state_nxt = S_INT_C1;
        end
      end
      S_OUT_A: begin
        ans_addr  = oi_r;
        state_nxt = S_OUT_B;
      end
      S_OUT_B: begin
        ocol_nxt  = ans_rdata.col;
        mat_addr  = {oi_r, ans_rdata.col};
        state_nxt = S_OUT_C;
      end
      S_OUT_C: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{out_row: oi_r, min_col: ocol_r, min_value: mat_rdata,
                          last_row: ({1'b0, oi_r} + 7'd1 == row_count_r)};
        if ({1'b0, oi_r} + 7'd1 == row_count_r) begin
          state_nxt = S_IDLE;
        end else begin
          oi_nxt    = oi_r + 6'd1;
          state_nxt = S_OUT_A;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `MMRM_ASSERT_IMPL(a_mid_result_busy, out_valid_r && !out_r.last_row, state_r != S_IDLE)
  `MMRM_ASSERT_NEXT(a_emit_strobe, state_r == S_OUT_C, out_valid_r)
  `MMRM_ASSERT_IMPL(a_row_in_range, out_valid_r, {1'b0, out_r.out_row} < row_count_r)
  `MMRM_ASSERT_IMPL(a_stack_cap, state_r == S_RED_FETCH, k_r <= m)
endmodule
`default_nettype wire

FILE: src/mmrm_ram.sv
`default_nettype none
module mmrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: tb/tb_monotone_matrix_row_minima_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_monotone_matrix_row_minima_unit;
  import mmrm_pkg::*;

  localparam int IN_BITS = $bits(in_t);

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_data;
  logic       out_valid;
  out_t       out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  monotone_matrix_row_minima_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  logic signed [31:0] mat [0:MAX_ROWS-1][0:MAX_COLS-1];
  bit                 written [0:MAX_ROWS-1][0:MAX_COLS-1];
  int                 stk_col [0:LEVELS-1][0:MAX_ROWS-1];
  int                 stk_pos [0:LEVELS-1][0:MAX_ROWS-1];
  int                 lvl_depth [0:LEVELS-1];
  int                 ans_col [0:MAX_ROWS-1];
  int                 ans_pos [0:MAX_ROWS-1];
  int                 rows_in_use;
  int                 cols_in_use;
  out_t               minima_q [$];
  int                 n_errors;
  int                 n_items;
  int                 n_results;
  int                 n_runs;
  bit                 no_gaps;

  function automatic void apply_register(logic [1:0] idx, logic [8:0] data);
    int v;
    if (idx == CFG_ROW_COUNT) begin
      v = data[6:0];
      rows_in_use = (v < 1) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
    end else if (idx == CFG_COL_COUNT) begin
      v = data;
      cols_in_use = (v < 1) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
    end
  endfunction

  function automatic void reduce_level(int lvl, int m, output int k);
    int in_cnt, c, r;
    in_cnt = (lvl == 0) ? cols_in_use : lvl_depth[lvl-1];
    k = 0;
    for (int i = 0; i < in_cnt; i++) begin
      c = (lvl == 0) ? i : stk_col[lvl-1][i];
      while (k > 0) begin
        r = (k << lvl) - 1;
        if (mat[r][c] >= mat[r][stk_col[lvl][k-1]]) break;
        k--;
      end
      if (k < m) begin
        stk_col[lvl][k] = c;
        stk_pos[lvl][k] = i;
        k++;
      end
    end
    lvl_depth[lvl] = k;
  endfunction

  function automatic void interpolate_level(int lvl, int m, int k);
    int first, r, stop, best, nr;
    first = 0;
    for (int i = 0; i < m; i += 2) begin
      r = ((i + 1) << lvl) - 1;
      stop = k - 1;
      if (i + 1 < m) begin
        nr = ((i + 2) << lvl) - 1;
        stop = ans_pos[nr % MAX_ROWS];
        if (stop > k - 1) stop = k - 1;
      end
      if (first > k - 1) first = k - 1;
      best = first;
      for (int c = first + 1; c <= stop; c++)
        if (mat[r][stk_col[lvl][c]] < mat[r][stk_col[lvl][best]]) best = c;
      if (r < MAX_ROWS) begin
        ans_col[r] = stk_col[lvl][best];
        ans_pos[r] = stk_pos[lvl][best];
      end
      first = stop;
    end
  endfunction

  function automatic void predict_minima();
    int m_of [0:LEVELS-1];
    int k_of [0:LEVELS-1];
    int deepest;
    out_t o;
    deepest = -1;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      m_of[lvl] = rows_in_use >> lvl;
      if (m_of[lvl] == 0) break;
      reduce_level(lvl, m_of[lvl], k_of[lvl]);
      if (k_of[lvl] == 0) break;
      deepest = lvl;
    end
    for (int lvl = deepest; lvl >= 0; lvl--)
      interpolate_level(lvl, m_of[lvl], k_of[lvl]);
    for (int i = 0; i < rows_in_use; i++) begin
      o.out_row   = i[5:0];
      o.min_col   = ans_col[i][7:0];
      o.min_value = mat[i][ans_col[i]];
      o.last_row  = (i + 1 == rows_in_use);
      minima_q = {minima_q, o};
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_gaps || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // caller is at a falling edge
  task automatic send_entry(in_t it, bit typed, out_t want);
    int n;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    mat[it.entry_row][it.entry_col] = it.entry_value;
    written[it.entry_row][it.entry_col] = 1'b1;
    n_items++;
    if (it.load_done) begin
      if (typed) begin
        minima_q = {minima_q, want};
      end else begin
        predict_minima();
      end
      n_runs++;
    end
    @(negedge clk);
    n = pick_gap();
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= in_t'(IN_BITS'({$urandom, $urandom}));
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (minima_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 9'($urandom);
    repeat (pick_gap()) @(negedge clk);
  endtask

  // shape: 0 monotone, 1 random, 2 patch of the previous contents
  task automatic load_and_solve(int shape);
    int   t, g, off, lr, lc;
    in_t  it;
    out_t none;
    none = '0;
    t = $urandom_range(0, cols_in_use - 1);
    lr = $urandom_range(0, rows_in_use - 1);
    lc = $urandom_range(0, cols_in_use - 1);
    for (int r = 0; r < rows_in_use; r++) begin
      off = $urandom_range(0, 2000000) - 1000000;
      if (r > 0) t = t + $urandom_range(0, 2);
      if (t > cols_in_use - 1) t = cols_in_use - 1;
      for (int c = 0; c < cols_in_use; c++) begin
        if (shape == 2 && written[r][c] && $urandom_range(0, 9) != 0) continue;
        if (r == lr && c == lc) continue;
        g = $urandom_range(0, 40);
        it.entry_row   = r[5:0];
        it.entry_col   = c[7:0];
        it.entry_value = (shape == 1) ? $urandom : off + g + (c - t) * (c - t) * 8;
        it.load_done   = 1'b0;
        send_entry(it, 1'b0, none);
        if ($urandom_range(0, 19) == 0 && rows_in_use < MAX_ROWS) begin
          it.entry_row   = 6'($urandom_range(rows_in_use, MAX_ROWS - 1));
          it.entry_col   = 8'($urandom);
          it.entry_value = $urandom;
          send_entry(it, 1'b0, none);
        end
      end
    end
    it.entry_row   = lr[5:0];
    it.entry_col   = lc[7:0];
    it.entry_value = (shape == 1 || !written[lr][lc]) ? $urandom : mat[lr][lc] + 1;
    it.load_done   = 1'b1;
    send_entry(it, 1'b0, none);
  endtask

  typedef struct {
    bit         is_cfg;
    logic [1:0] idx;
    logic [8:0] data;
    in_t        item;
    bit         typed;
    out_t       want;
  } step_t;

  step_t directed [] = '{
    '{1, CFG_ROW_COUNT, 9'd0,   '0, 0, '0},
    '{1, CFG_COL_COUNT, 9'd0,   '0, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd0, 8'd0, 32'sh80000000, 1'b1}, 1,
      '{6'd0, 8'd0, 32'sh80000000, 1'b1}},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd0, 8'd0, 32'sh7fffffff, 1'b1}, 1,
      '{6'd0, 8'd0, 32'sh7fffffff, 1'b1}},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd0, 8'd0, 32'sh0, 1'b1}, 1,
      '{6'd0, 8'd0, 32'sh0, 1'b1}},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd63, 8'd255, 32'shffffffff, 1'b0}, 0, '0},
    '{1, CFG_ROW_COUNT, 9'd3,   '0, 0, '0},
    '{1, CFG_COL_COUNT, 9'd2,   '0, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd0, 8'd0, 32'sd5, 1'b0}, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd0, 8'd1, 32'sd3, 1'b0}, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd1, 8'd0, -32'sd1, 1'b0}, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd1, 8'd1, 32'sd7, 1'b0}, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd2, 8'd0, 32'sd2, 1'b0}, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd2, 8'd1, 32'sd2, 1'b1}, 0, '0},
    '{0, CFG_ROW_COUNT, 9'd0, '{6'd1, 8'd1, -32'sd9, 1'b1}, 0, '0}
  };

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (minima_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        n_errors++;
      end else begin
        if (out_data.out_row !== minima_q[0].out_row ||
            out_data.min_col !== minima_q[0].min_col ||
            out_data.min_value !== minima_q[0].min_value ||
            out_data.last_row !== minima_q[0].last_row) begin
          $display("%0t: expected %p actual %p", $time, minima_q[0], out_data);
          n_errors++;
        end
        void'(minima_q.pop_front());
        n_results++;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data  = '0;
    n_errors  = 0;
    n_items   = 0;
    n_results = 0;
    n_runs    = 0;
    no_gaps   = 1'b0;
    rows_in_use = 64;
    cols_in_use = 256;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain_results();
        write_register(directed[i].idx, directed[i].data);
      end else begin
        send_entry(directed[i].item, directed[i].typed, directed[i].want);
      end
    end

    drain_results();
    write_register(CFG_ROW_COUNT, 9'd127);
    write_register(CFG_COL_COUNT, 9'd1);
    load_and_solve(0);
    drain_results();
    write_register(CFG_ROW_COUNT, 9'd1);
    write_register(CFG_COL_COUNT, 9'd511);
    load_and_solve(1);

    while (n_items < 400) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        drain_results();
        write_register(CFG_ROW_COUNT, 9'($urandom_range(1, 9) | ($urandom_range(0, 3) << 7)));
        write_register(CFG_COL_COUNT, 9'($urandom_range(1, 10)));
      end
      load_and_solve($urandom_range(0, 2));
    end
    no_gaps = 1'b0;

    drain_results();
    repeat (50) @(posedge clk);
    $display("%0d entries loaded over %0d runs, %0d row minima checked",
             n_items, n_runs, n_results);
    $display("sizes from 1x1 to 64x1 and 1x256, monotone, random and patched matrices");
    if (n_errors == 0 && minima_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
